/* src/mlfd_pkg.sv */
// shared types and constants for the magic-word length-prefixed frame deframer
// used by mlfd_step and magic_length_frame_deframer_unit; no dependencies
package mlfd_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int LEN_W       = 24;
   localparam logic [31:0] LengthCap = 32'((64'd1 << LENGTH_BITS) - 64'd1);

   localparam logic [31:0] MagicReset = 32'h7374_6172;
   localparam logic [23:0] MaxReset   = 24'd153600;

   // configuration register indexes
   localparam logic CSR_MAGIC_WORD = 1'b0;
   localparam logic CSR_MAX_FRAME  = 1'b1;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_HEADER  = 2'd1,
      EV_PAYLOAD = 2'd2,
      EV_EMPTY   = 2'd3
   } event_type;

   typedef enum logic [5:0] {
      PH_HUNT0   = 6'b000001,
      PH_HUNT1   = 6'b000010,
      PH_HUNT2   = 6'b000100,
      PH_HUNT3   = 6'b001000,
      PH_LENGTH  = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [1:0]       len_count;
      logic [23:0]      len_acc;    // first three length bytes
      logic [LEN_W-1:0] pos;
      logic [LEN_W-1:0] eff_len;
      logic             clamped;
   } state_type;

   typedef struct packed {
      event_type        event_res;
      logic [7:0]       payload_byte;
      logic [LEN_W-1:0] byte_offset;
      logic [LEN_W-1:0] frame_length;
      logic             truncated;
      logic             last;
   } result_type;

endpackage

/* src/magic_length_frame_deframer_unit.sv */
// top level of the magic-word length-prefixed frame deframer
// depends on mlfd_pkg and mlfd_step
//
// Usage: one received link byte enters per req_ item; every accepted byte
// yields exactly one rsp_ item. Bytes are matched against the four sync bytes
// of the magic word (msb first), then four bytes give a signed little-endian
// length, then that many payload bytes follow with offset and a last flag.
// Event codes: none, header complete, payload byte, empty frame done.
// The result of a byte accepted at one edge is registered and shown at rsp_
// from the next cycle. Throughput is one byte per cycle while rsp_ready is
// high, set by the single register stage after the step logic.
// When the receiver stalls, the result register holds its item and req_ready
// drops until that item is taken; with rsp_ready high bytes stream freely.
// The csr_ port writes magic_word (index 0) or max_frame_bytes (index 1) at
// any edge with csr_write_en high; write only while the block is idle.
// Reset returns to the hunt for the first sync byte, restores the register
// defaults and empties the result register.
module magic_length_frame_deframer_unit import mlfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_event_res,
   output logic [7:0]       rsp_payload_byte,
   output logic [LEN_W-1:0] rsp_byte_offset,
   output logic [LEN_W-1:0] rsp_frame_length,
   output logic             rsp_truncated,
   output logic             rsp_last,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);

   state_type   state_ff, state_in;
   result_type  result_ff, result_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] magic_ff, magic_in;
   logic [23:0] max_ff, max_in;
   logic        accept;

   mlfd_step u_step (
      .cur             (state_ff),
      .rx_byte         (req_rx_byte),
      .magic_word      (magic_ff),
      .max_frame_bytes (max_ff),
      .nxt             (state_in),
      .res             (result_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      magic_in = magic_ff;
      max_in   = max_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAGIC_WORD: magic_in = csr_wdata;
            CSR_MAX_FRAME:  max_in   = csr_wdata[23:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{phase: PH_HUNT0, len_count: 2'd0, len_acc: '0,
                           pos: '0, eff_len: '0, clamped: 1'b0};
         rsp_valid_ff <= 1'b0;
         magic_ff     <= MagicReset;
         max_ff       <= MaxReset;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         magic_ff     <= magic_in;
         max_ff       <= max_in;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = result_ff.event_res;
   assign rsp_payload_byte = result_ff.payload_byte;
   assign rsp_byte_offset  = result_ff.byte_offset;
   assign rsp_frame_length = result_ff.frame_length;
   assign rsp_truncated    = result_ff.truncated;
   assign rsp_last         = result_ff.last;

`ifndef NO_ASSERTIONS
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_NONE |->
         rsp_payload_byte == 8'd0 && rsp_byte_offset == '0 && rsp_frame_length == '0
         && !rsp_truncated && !rsp_last)
      else $error("none event carries nonzero fields");

   a_last_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_event_res == EV_PAYLOAD || rsp_event_res == EV_EMPTY)
      else $error("last flag on wrong event");

   a_offset_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_PAYLOAD |-> rsp_byte_offset < rsp_frame_length)
      else $error("payload offset beyond frame length");

   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while result stalled");

   a_payload_phase_len: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_PAYLOAD |-> state_ff.eff_len != '0
         && state_ff.pos < state_ff.eff_len)
      else $error("payload phase with bad position");
`endif

endmodule

/* src/mlfd_step.sv */
// next-state and result logic for one received byte of the deframer
// depends on mlfd_pkg
module mlfd_step import mlfd_pkg::*; (
   input  state_type   cur,
   input  logic [7:0]  rx_byte,
   input  logic [31:0] magic_word,
   input  logic [23:0] max_frame_bytes,
   output state_type   nxt,
   output result_type  res
);

   logic [7:0]  want;
   logic [31:0] full_len;
   logic [31:0] cap;
   logic        clip;
   logic [LEN_W-1:0] clipped_len;
   logic [LEN_W:0]   pos_inc;
   logic        is_last;

   // sync byte expected in the current hunt position, msb first
   always_comb begin
      unique case (cur.phase)
         PH_HUNT1: want = magic_word[23:16];
         PH_HUNT2: want = magic_word[15:8];
         PH_HUNT3: want = magic_word[7:0];
         default:  want = magic_word[31:24];
      endcase
   end

   assign full_len    = {rx_byte, cur.len_acc};
   assign cap         = ({8'd0, max_frame_bytes} < LengthCap) ? {8'd0, max_frame_bytes}
                                                              : LengthCap;
   assign clip        = full_len > cap;
   assign clipped_len = clip ? cap[LEN_W-1:0] : full_len[LEN_W-1:0];
   assign pos_inc     = {1'b0, cur.pos} + {{LEN_W{1'b0}}, 1'b1};
   assign is_last     = pos_inc >= {1'b0, cur.eff_len};

   always_comb begin
      nxt = cur;
      res = '0;
      res.event_res = EV_NONE;
      unique case (cur.phase)
         PH_LENGTH: begin
            if (cur.len_count != 2'd3) begin
               nxt.len_acc   = cur.len_acc | ({16'd0, rx_byte} << {cur.len_count, 3'b000});
               nxt.len_count = cur.len_count + 2'd1;
            end else begin
               nxt.len_count = 2'd0;
               nxt.len_acc   = '0;
               nxt.pos       = '0;
               if (full_len == 32'd0 || full_len[31]) begin
                  // zero or negative length
                  nxt.clamped   = 1'b0;
                  nxt.eff_len   = '0;
                  nxt.phase     = PH_HUNT0;
                  res.event_res = EV_EMPTY;
                  res.last      = 1'b1;
               end else begin
                  nxt.clamped = clip;
                  nxt.eff_len = clipped_len;
                  if (clipped_len == '0) begin
                     nxt.phase     = PH_HUNT0;
                     res.event_res = EV_EMPTY;
                     res.truncated = clip;
                     res.last      = 1'b1;
                  end else begin
                     nxt.phase        = PH_PAYLOAD;
                     res.event_res    = EV_HEADER;
                     res.frame_length = clipped_len;
                     res.truncated    = clip;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            res.event_res    = EV_PAYLOAD;
            res.payload_byte = rx_byte;
            res.byte_offset  = cur.pos;
            res.frame_length = cur.eff_len;
            res.truncated    = cur.clamped;
            res.last         = is_last;
            if (is_last) begin
               nxt.phase = PH_HUNT0;
               nxt.pos   = '0;
            end else begin
               nxt.pos = pos_inc[LEN_W-1:0];
            end
         end
         default: begin
            // sync hunt; a mismatching byte is not rechecked
            if (rx_byte == want) begin
               unique case (cur.phase)
                  PH_HUNT1: nxt.phase = PH_HUNT2;
                  PH_HUNT2: nxt.phase = PH_HUNT3;
                  PH_HUNT3: begin
                     nxt.phase     = PH_LENGTH;
                     nxt.len_count = 2'd0;
                     nxt.len_acc   = '0;
                  end
                  default:  nxt.phase = PH_HUNT1;
               endcase
            end else begin
               nxt.phase = PH_HUNT0;
            end
         end
      endcase
   end

endmodule

/* bench/magic_length_frame_deframer_checker.sv */
// checker for the frame deframer: watches the byte, result and register ports,
// tracks its own copy of the deframer state and compares every result item
// depends on mlfd_pkg for the event and phase types
module magic_length_frame_deframer_checker import mlfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [1:0]       rsp_event_res,
   input  logic [7:0]       rsp_payload_byte,
   input  logic [LEN_W-1:0] rsp_byte_offset,
   input  logic [LEN_W-1:0] rsp_frame_length,
   input  logic             rsp_truncated,
   input  logic             rsp_last,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata,
   output int               mismatch_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PRINTED = 100;

   result_type       deframed_q [$];
   logic [31:0]      magic_cfg;
   logic [LEN_W-1:0] max_cfg;

   phase_type        phase;
   logic [1:0]       len_count;
   logic [31:0]      len_acc;
   logic [LEN_W-1:0] pos;
   logic [LEN_W-1:0] eff_len;
   logic             clamped;

   int mismatches = 0;
   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_PRINTED)
         $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // one received byte through the sync hunt, length gathering or payload
   task automatic advance_deframer(input logic [7:0] rx, output result_type res);
      logic [31:0] full_len;
      logic [31:0] cap;
      int          idx;
      res = '0;
      case (phase)
         PH_LENGTH: begin
            full_len = len_acc | (32'(rx) << (8 * len_count));
            if (len_count != 2'd3) begin
               len_acc = full_len;
               len_count = len_count + 2'd1;
            end else begin
               len_count = 2'd0;
               len_acc = '0;
               if (full_len == 32'd0 || full_len[31]) begin
                  // zero or negative length
                  clamped = 1'b0;
                  eff_len = '0;
                  phase = PH_HUNT0;
                  res.event_res = EV_EMPTY;
                  res.last = 1'b1;
               end else begin
                  cap = (32'(max_cfg) < LengthCap) ? 32'(max_cfg) : LengthCap;
                  clamped = (full_len > cap);
                  eff_len = clamped ? LEN_W'(cap) : LEN_W'(full_len);
                  pos = '0;
                  if (eff_len == '0) begin
                     // limit of zero clamps every length away
                     phase = PH_HUNT0;
                     res.event_res = EV_EMPTY;
                     res.truncated = clamped;
                     res.last = 1'b1;
                  end else begin
                     phase = PH_PAYLOAD;
                     res.event_res = EV_HEADER;
                     res.frame_length = eff_len;
                     res.truncated = clamped;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            res.event_res = EV_PAYLOAD;
            res.payload_byte = rx;
            res.byte_offset = pos;
            res.frame_length = eff_len;
            res.truncated = clamped;
            res.last = ({1'b0, pos} + 1'b1 >= {1'b0, eff_len});
            if (res.last) begin
               phase = PH_HUNT0;
               pos = '0;
            end else begin
               pos = pos + 1'b1;
            end
         end
         default: begin
            case (phase)
               PH_HUNT1: idx = 1;
               PH_HUNT2: idx = 2;
               PH_HUNT3: idx = 3;
               default:  idx = 0;
            endcase
            // a mismatching byte is dropped, not retried as the first sync byte
            if (rx != magic_cfg[31 - 8 * idx -: 8]) begin
               phase = PH_HUNT0;
            end else begin
               case (idx)
                  0: phase = PH_HUNT1;
                  1: phase = PH_HUNT2;
                  2: phase = PH_HUNT3;
                  default: begin
                     phase = PH_LENGTH;
                     len_count = 2'd0;
                     len_acc = '0;
                  end
               endcase
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type fresh;
      if (reset) begin
         magic_cfg = MagicReset;
         max_cfg = MaxReset;
         phase = PH_HUNT0;
         len_count = 2'd0;
         len_acc = '0;
         pos = '0;
         eff_len = '0;
         clamped = 1'b0;
         deframed_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               report_mismatch("unexpected item, event", 32'(rsp_event_res), 32'd0);
            end else begin
               want = deframed_q.pop_front();
               if (rsp_event_res !== want.event_res)
                  report_mismatch("event_res", 32'(rsp_event_res), 32'(want.event_res));
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", 32'(rsp_payload_byte),
                                  32'(want.payload_byte));
               if (rsp_byte_offset !== want.byte_offset)
                  report_mismatch("byte_offset", 32'(rsp_byte_offset),
                                  32'(want.byte_offset));
               if (rsp_frame_length !== want.frame_length)
                  report_mismatch("frame_length", 32'(rsp_frame_length),
                                  32'(want.frame_length));
               if (rsp_truncated !== want.truncated)
                  report_mismatch("truncated", 32'(rsp_truncated), 32'(want.truncated));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && req_ready) begin
            advance_deframer(req_rx_byte, fresh);
            deframed_q.push_back(fresh);
         end
         if (csr_write_en) begin
            if (csr_index == CSR_MAGIC_WORD)
               magic_cfg = csr_wdata;
            else
               max_cfg = csr_wdata[LEN_W-1:0];
         end
      end
      outstanding <= deframed_q.size();
   end

endmodule

/* bench/magic_length_frame_deframer_unit_tb.sv */
// top of the frame deframer bench: clock, reset, byte stimulus, register
// settings and receiver stalls; the checker module does all comparing
// depends on mlfd_pkg, magic_length_frame_deframer_unit and the checker
module magic_length_frame_deframer_unit_tb;
   import mlfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS = 100;
   localparam int LONG_HOLD   = 100;
   localparam int STUCK_LIMIT = 500;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_event_res;
   logic [7:0]       rsp_payload_byte;
   logic [LEN_W-1:0] rsp_byte_offset;
   logic [LEN_W-1:0] rsp_frame_length;
   logic             rsp_truncated;
   logic             rsp_last;
   logic             csr_write_en = 1'b0;
   logic             csr_index = CSR_MAGIC_WORD;
   logic [31:0]      csr_wdata = 32'h0;

   int mismatch_count;
   int outstanding;

   logic [31:0]      cur_magic = MagicReset;
   logic [LEN_W-1:0] cur_max = MaxReset;
   bit               idle_on = 1'b1;
   bit               hold_request = 1'b0;
   bit               hold_served = 1'b0;
   int               frame_items;
   int               stuck_cycles = 0;

   magic_length_frame_deframer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_frame_length (rsp_frame_length),
      .rsp_truncated    (rsp_truncated),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   magic_length_frame_deframer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_frame_length (rsp_frame_length),
      .rsp_truncated    (rsp_truncated),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      if (idle_on && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every predicted item has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] magic, input logic [LEN_W-1:0] max_len);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MAGIC_WORD;
      csr_wdata <= magic;
      @(posedge clock);
      csr_index <= CSR_MAX_FRAME;
      csr_wdata <= 32'(max_len);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_magic = magic;
      cur_max = max_len;
   endtask

   task automatic send_header(input logic [31:0] length);
      for (int i = 3; i >= 0; i--) send_byte(cur_magic[8 * i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(length[8 * i +: 8]);
   endtask

   task automatic send_frame(input logic [31:0] length);
      int body;
      if (length == 32'd0 || length[31])
         body = 0;
      else
         body = (length > 32'(cur_max)) ? int'(cur_max) : int'(length);
      send_header(length);
      for (int i = 0; i < body; i++) send_byte(8'($urandom));
      frame_items += 8 + body;
   endtask

   task automatic random_frame();
      logic [31:0] length;
      int          pick;
      int          depth;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else if (pick < 6) begin
         // sync sequence cut short by a random byte
         depth = $urandom_range(1, 3);
         for (int i = 0; i < depth; i++) send_byte(cur_magic[31 - 8 * i -: 8]);
         send_byte(8'($urandom));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0)
         length = 32'd0;
      else if (pick == 1)
         length = {1'b1, 31'($urandom)};
      else if (pick < 4 && cur_max < 64)
         length = $urandom_range(0, 1) ? {1'b0, 31'($urandom)}
                                       : 32'(cur_max) + $urandom_range(1, 3);
      else
         length = $urandom_range(1, 8);
      send_frame(length);
   endtask

   task automatic run_phase(input logic [31:0] magic, input logic [LEN_W-1:0] max_len,
                            input bit idling);
      drain();
      program_regs(magic, max_len);
      idle_on <= idling;
      frame_items = 0;
      while (frame_items < PHASE_ITEMS) random_frame();
   endtask

   initial begin
      logic [7:0] warmup [$];
      // no sync after a repeated first byte, then negative, zero and short frames
      warmup = '{8'h73, 8'h73, 8'h74, 8'h61, 8'h72,
                 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h80,
                 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h73, 8'h74, 8'h61, 8'h72, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (warmup[i]) send_byte(warmup[i]);

      run_phase(32'h0000_0000, 24'd1, 1'b1);
      run_phase(32'hFFFF_FFFF, 24'd0, 1'b1);
      run_phase(32'h4141_4142, 24'd5, 1'b0);
      // receiver holds off while bytes keep coming
      hold_request <= 1'b1;
      repeat (8) random_frame();
      for (int k = 0; k < 6; k++)
         run_phase($urandom, LEN_W'($urandom_range(1, 12)), k % 3 != 2);
      run_phase(MagicReset, MaxReset, 1'b1);

      // no idling from here on; widest limit, ending inside an oversize frame
      run_phase($urandom, 24'hFF_FFFF, 1'b0);
      send_header(32'h7FFF_FFFF);
      repeat (60) send_byte(8'($urandom));

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
